FILE: src/fixed_point_alu_unit_assert.svh
// assertion macros shared by the alu pipeline
`ifndef FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define FIXED_POINT_ALU_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define FPA_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fixed point alu check failed");
// condition never holds out of reset
`define FPA_ASSERT_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("fixed point alu check failed");
`else
`define FPA_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define FPA_ASSERT_NEVER(lbl, ck, rn, cond)
`endif
`endif

FILE: src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// command codes and shared types of the fixed point alu
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_LT       = 4'd4,
    CMD_GT       = 4'd5,
    CMD_LE       = 4'd6,
    CMD_GE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  // status bits returned by the multiplier and divider
  typedef struct packed {
    logic saturated;
    logic div_zero;
  } arith_flags_t;

endpackage
`default_nettype wire

FILE: src/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// two stage signed fixed point multiply, round half away, saturate
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_mul #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  wire                            clk,
  input  wire  logic signed [DATA_WIDTH-1:0] a,
  input  wire  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0]       value,
  output fpa_pkg::arith_flags_t              flags
);

  localparam int PW = 2 * DATA_WIDTH + 1;
  localparam logic [PW-1:0] LIM_POS = {(DATA_WIDTH + 2)'(0), {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [PW-1:0] LIM_NEG = LIM_POS + PW'(1);
  localparam logic [PW-1:0] HALF    = PW'(1) << (FRACTION_BITS - 1);

  logic [DATA_WIDTH-1:0]   a_mag, b_mag;
  logic [2*DATA_WIDTH-1:0] prod_r;
  logic                    neg_r;
  logic [PW-1:0]           rnd, q, lim, m;
  logic                    sat;
  logic signed [DATA_WIDTH-1:0] value_r;
  logic                    sat_r;

  // operand magnitudes
  assign a_mag = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
  assign b_mag = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);

  // stage one: magnitude product
  always_ff @(posedge clk) begin
    prod_r <= a_mag * b_mag;
    neg_r  <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
  end

  // stage two: round, clamp, apply sign
  assign rnd = {1'b0, prod_r} + HALF;
  assign q   = rnd >> FRACTION_BITS;
  assign lim = neg_r ? LIM_NEG : LIM_POS;
  assign sat = q > lim;
  assign m   = sat ? lim : q;

  always_ff @(posedge clk) begin
    value_r <= neg_r ? DATA_WIDTH'(-m[DATA_WIDTH-1:0]) : m[DATA_WIDTH-1:0];
    sat_r   <= sat;
  end

  assign value           = value_r;
  assign flags.saturated = sat_r;
  assign flags.div_zero  = 1'b0;

endmodule
`default_nettype wire

FILE: src/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// pipelined restoring divider, one quotient bit per stage, rounded and clamped
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  wire                            clk,
  input  wire  logic signed [DATA_WIDTH-1:0] a,
  input  wire  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0]       value,
  output fpa_pkg::arith_flags_t              flags
);

  // numerator is 2*|a|*2^F, one stage per quotient bit
  localparam int NW = DATA_WIDTH + FRACTION_BITS + 1;
  localparam logic [NW-1:0] LIM_POS = {(NW - DATA_WIDTH + 1)'(0), {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [NW-1:0] LIM_NEG = LIM_POS + NW'(1);

  logic [DATA_WIDTH-1:0] a_mag, b_mag;
  logic [DATA_WIDTH-1:0] rem_r [NW];
  logic [DATA_WIDTH-1:0] d_r   [NW];
  logic [NW-1:0]         num_r [NW];
  logic [NW-1:0]         quo_r [NW];
  logic                  neg_r [NW];
  logic                  dz_r  [NW];

  assign a_mag = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
  assign b_mag = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);

  // compare and subtract stages
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DATA_WIDTH-1:0] rem_in, d_in;
    logic [NW-1:0]         num_in, quo_in;
    logic                  neg_in, dz_in, take;
    logic [DATA_WIDTH:0]   trial, diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign d_in   = b_mag;
      assign num_in = {a_mag, (FRACTION_BITS + 1)'(0)};
      assign quo_in = '0;
      assign neg_in = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      assign dz_in  = (b == '0);
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign d_in   = d_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign neg_in = neg_r[s-1];
      assign dz_in  = dz_r[s-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign take  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      rem_r[s] <= take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      d_r[s]   <= d_in;
      num_r[s] <= num_in << 1;
      quo_r[s] <= {quo_in[NW-2:0], take};
      neg_r[s] <= neg_in;
      dz_r[s]  <= dz_in;
    end
  end

  // final stage: round half away, clamp, sign
  logic [NW:0]   rnd_sum;
  logic [NW-1:0] q, lim, m;
  logic          sat, ng, dz;
  logic signed [DATA_WIDTH-1:0] value_r;
  logic          sat_r, dz_out_r;

  assign ng      = neg_r[NW-1];
  assign dz      = dz_r[NW-1];
  assign rnd_sum = {1'b0, quo_r[NW-1]} + (NW + 1)'(1);
  assign q       = rnd_sum[NW:1];
  assign lim     = ng ? LIM_NEG : LIM_POS;
  assign sat     = !dz && (q > lim);
  assign m       = (q > lim) ? lim : q;

  always_ff @(posedge clk) begin
    if (dz) begin
      value_r <= '0;
    end else begin
      value_r <= ng ? DATA_WIDTH'(-m[DATA_WIDTH-1:0]) : m[DATA_WIDTH-1:0];
    end
    sat_r    <= sat;
    dz_out_r <= dz;
  end

  assign value           = value_r;
  assign flags.saturated = sat_r;
  assign flags.div_zero  = dz_out_r;

endmodule
`default_nettype wire

FILE: src/fixed_point_alu_unit.sv
// throughput: one request per cycle, busy never rises
// the depth is set by the divider, one quotient bit per pipeline stage
// every operation runs through the same depth so results leave in order
// reset (synchronous, rst_n low) clears all valid bits; no results come out of reset
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// pipelined signed fixed point alu with rounding multiply and divide
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_unit_assert.svh"
module fixed_point_alu_unit #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  logic [3:0]   in_cmd,
  input  wire  logic signed [31:0] in_operand_a,
  input  wire  logic signed [31:0] in_operand_b,
  output logic               out_strobe,
  output logic signed [31:0] out_result_value,
  output logic               out_compare_true,
  output logic               out_divide_by_zero,
  output logic               out_saturated
);

  localparam int NW = DATA_WIDTH + FRACTION_BITS + 1;
  localparam int NS = NW + 1;
  localparam logic signed [31:0] SAT_MAX = 32'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [31:0] SAT_MIN = -SAT_MAX - 32'sd1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  assign busy = 1'b0;

  // input register
  logic           s1_valid_r;
  fpa_pkg::cmd_t  s1_cmd_r;
  word_t          s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_cmd_r <= fpa_pkg::cmd_t'(in_cmd);
    s1_a_r   <= in_operand_a[DATA_WIDTH-1:0];
    s1_b_r   <= in_operand_b[DATA_WIDTH-1:0];
  end

  // combinational operations on the input register
  word_t simple_val;
  logic  simple_cmp;

  always_comb begin
    simple_val = '0;
    simple_cmp = 1'b0;
    unique case (s1_cmd_r)
      fpa_pkg::CMD_ADD:      simple_val = s1_a_r + s1_b_r;
      fpa_pkg::CMD_SUB:      simple_val = s1_a_r - s1_b_r;
      fpa_pkg::CMD_MUL:      simple_val = '0;
      fpa_pkg::CMD_DIV:      simple_val = '0;
      fpa_pkg::CMD_LT:       simple_cmp = s1_a_r < s1_b_r;
      fpa_pkg::CMD_GT:       simple_cmp = s1_a_r > s1_b_r;
      fpa_pkg::CMD_LE:       simple_cmp = s1_a_r <= s1_b_r;
      fpa_pkg::CMD_GE:       simple_cmp = s1_a_r >= s1_b_r;
      fpa_pkg::CMD_EQ:       simple_cmp = s1_a_r == s1_b_r;
      fpa_pkg::CMD_NE:       simple_cmp = s1_a_r != s1_b_r;
      fpa_pkg::CMD_MIN:      simple_val = (s1_a_r < s1_b_r) ? s1_a_r : s1_b_r;
      fpa_pkg::CMD_MAX:      simple_val = (s1_a_r < s1_b_r) ? s1_b_r : s1_a_r;
      fpa_pkg::CMD_INC:      simple_val = s1_a_r + word_t'(1);
      fpa_pkg::CMD_DEC:      simple_val = s1_a_r - word_t'(1);
      fpa_pkg::CMD_FROM_INT: simple_val = s1_a_r << FRACTION_BITS;
      fpa_pkg::CMD_TO_INT:   simple_val = s1_a_r >>> FRACTION_BITS;
      default:               simple_val = '0;
    endcase
  end

  // multiply and divide units
  word_t                 mul_val, div_val;
  fpa_pkg::arith_flags_t mul_flags, div_flags;

  fpa_mul #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk   (clk),
    .a     (s1_a_r),
    .b     (s1_b_r),
    .value (mul_val),
    .flags (mul_flags)
  );

  fpa_div #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .a     (s1_a_r),
    .b     (s1_b_r),
    .value (div_val),
    .flags (div_flags)
  );

  // side pipe carries the request alongside the divider, mul merges at stage two
  logic          side_v_r   [NS];
  fpa_pkg::cmd_t side_cmd_r [NS];
  word_t         side_val_r [NS];
  logic          side_cmp_r [NS];
  logic          side_sat_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_v_r[k] <= 1'b0;
        end else begin
          side_v_r[k] <= s1_valid_r;
        end
        side_cmd_r[k] <= s1_cmd_r;
        side_val_r[k] <= simple_val;
        side_cmp_r[k] <= simple_cmp;
        side_sat_r[k] <= 1'b0;
      end
    end else if (k == 2) begin : g_merge
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_v_r[k] <= 1'b0;
        end else begin
          side_v_r[k] <= side_v_r[k-1];
        end
        side_cmd_r[k] <= side_cmd_r[k-1];
        side_cmp_r[k] <= side_cmp_r[k-1];
        if (side_cmd_r[k-1] == fpa_pkg::CMD_MUL) begin
          side_val_r[k] <= mul_val;
          side_sat_r[k] <= mul_flags.saturated;
        end else begin
          side_val_r[k] <= side_val_r[k-1];
          side_sat_r[k] <= side_sat_r[k-1];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_v_r[k] <= 1'b0;
        end else begin
          side_v_r[k] <= side_v_r[k-1];
        end
        side_cmd_r[k] <= side_cmd_r[k-1];
        side_val_r[k] <= side_val_r[k-1];
        side_cmp_r[k] <= side_cmp_r[k-1];
        side_sat_r[k] <= side_sat_r[k-1];
      end
    end
  end

  // output register, divider result joins here
  logic  strobe_r, cmp_r, dz_r, sat_r;
  word_t val_r;
  logic  last_div;

  assign last_div = side_cmd_r[NS-1] == fpa_pkg::CMD_DIV;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= side_v_r[NS-1];
    end
    val_r <= last_div ? div_val : side_val_r[NS-1];
    cmp_r <= side_cmp_r[NS-1];
    dz_r  <= last_div && div_flags.div_zero;
    sat_r <= last_div ? div_flags.saturated : side_sat_r[NS-1];
  end

  assign out_strobe         = strobe_r;
  assign out_result_value   = 32'(val_r);
  assign out_compare_true   = cmp_r;
  assign out_divide_by_zero = dz_r;
  assign out_saturated      = sat_r;

  // checks
  `FPA_ASSERT_IMPL(a_dz_zero, clk, rst_n, out_strobe && out_divide_by_zero, out_result_value == 32'sd0 && !out_saturated)
  `FPA_ASSERT_IMPL(a_cmp_zero, clk, rst_n, out_strobe && out_compare_true, out_result_value == 32'sd0 && !out_saturated)
  `FPA_ASSERT_IMPL(a_sat_rail, clk, rst_n, out_strobe && out_saturated, out_result_value == SAT_MAX || out_result_value == SAT_MIN)
  `FPA_ASSERT_NEVER(a_busy_low, clk, rst_n, busy)

endmodule
`default_nettype wire
